>>> rtl/core/sv39pt_pkg.sv
// Shared types and constants for the Sv39 page table map and walk block.
package sv39pt_pkg;

  localparam int VA_W        = 39;
  localparam int PPN_W       = 44;
  localparam int PTE_W       = 64;
  localparam int COUNT_W     = 16;
  localparam int PERM_W      = 5;
  localparam int STATUS_W    = 3;
  localparam int ENTRY_IDX_W = 9;
  localparam int PAGE_OFS_W  = 12;

  localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_VA_LIMIT    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_COUNT  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISALIGNED  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_MAPPED      = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_POOL_EMPTY  = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT = 3'd6;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_MAP    = 1'b1;

  localparam logic [1:0] TOP_LEVEL  = 2'd2;
  localparam logic [1:0] LEAF_LEVEL = 2'd0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PAGE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

  // Operand selection for the shared 44-bit adder.
  typedef enum logic [1:0] {
    ADD_UNBASE,
    ADD_ALLOC,
    ADD_STEP
  } add_op_t;

endpackage

>>> rtl/core/sv39pt_table_ram.sv
// Single-port table store with registered read data.
module sv39pt_table_ram #(
  parameter int ADDR_W = 12
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [ADDR_W-1:0]              addr,
  input  logic [sv39pt_pkg::PTE_W-1:0]   wdata,
  output logic [sv39pt_pkg::PTE_W-1:0]   rdata
);
  import sv39pt_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [PTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/sv39_page_table_map_walk_top.sv
// Top level: Sv39 page table walker and mapper over a pool of table pages.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  mode, virt_addr, phys_page, page_count, perm
//   out      out_valid/ out_stall status, leaf_entry, pages_done
//   cfg      cfg_wr_en            cfg_wr_data (pool base page)
//
// Each walk level uses the single table memory port in two steps (read, then
// evaluate); a mapped page adds S_PAGE to the three levels, and every table
// page that has to be allocated is first cleared, all 512 entries. Acceptance
// (S_IDLE) and the result (S_FINISH) are states of their own.
// After reset the root page is cleared before in_stall falls.
// in_stall is high while a transaction is being worked; a finished result waits
// in the output register while out_stall is high.
module sv39_page_table_map_walk_top #(
  parameter int          POOL_PAGES = 8,
  parameter logic [38:0] VA_LIMIT   = 39'd274877906944
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sv39pt_pkg::PPN_W-1:0]       cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [sv39pt_pkg::VA_W-1:0]        virt_addr,
  input  logic [sv39pt_pkg::PPN_W-1:0]       phys_page,
  input  logic [sv39pt_pkg::COUNT_W-1:0]     page_count,
  input  logic [sv39pt_pkg::PERM_W-1:0]      perm,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sv39pt_pkg::STATUS_W-1:0]    status,
  output logic [sv39pt_pkg::PTE_W-1:0]       leaf_entry,
  output logic [sv39pt_pkg::COUNT_W-1:0]     pages_done
);
  import sv39pt_pkg::*;

  localparam int PG_W   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CNT_W  = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W = PG_W + ENTRY_IDX_W;
  localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(POOL_PAGES);

  state_t state, state_next;

  logic [PPN_W-1:0]       pool_base;
  logic [CNT_W-1:0]       next_free, next_free_next;
  logic                   boot, boot_next;
  logic [PG_W-1:0]        clr_page, clr_page_next;
  logic [ENTRY_IDX_W-1:0] clr_cnt, clr_cnt_next;

  logic                   mode_r, mode_r_next;
  logic [VA_W:0]          va, va_next;
  logic [PPN_W-1:0]       ppn, ppn_next;
  logic [COUNT_W-1:0]     count, count_next;
  logic [PERM_W-1:0]      perm_r, perm_r_next;
  logic [COUNT_W-1:0]     done, done_next;
  logic [PTE_W-1:0]       leaf, leaf_next;
  logic [STATUS_W-1:0]    st, st_next;
  logic [1:0]             level, level_next;
  logic [PG_W-1:0]        page, page_next;
  logic [ADDR_W-1:0]      slot, slot_next;

  logic                   out_valid_next;
  logic [STATUS_W-1:0]    status_next;
  logic [PTE_W-1:0]       leaf_entry_next;
  logic [COUNT_W-1:0]     pages_done_next;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [PTE_W-1:0]       ram_wdata;
  logic [PTE_W-1:0]       ram_rdata;

  add_op_t                add_op;
  logic [PPN_W-1:0]       add_a, add_b, add_sum;
  logic                   add_cin;

  logic [ENTRY_IDX_W-1:0] lvl_idx;
  logic [PTE_W-1:0]       leaf_pte;
  logic [COUNT_W-1:0]     done_inc;

  sv39pt_table_ram #(
    .ADDR_W (ADDR_W)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    case (level)
      2'd2:    lvl_idx = va[38:30];
      2'd1:    lvl_idx = va[29:21];
      default: lvl_idx = va[20:12];
    endcase
  end

  // The one adder serves rebasing a pointer, forming a new table pointer and
  // stepping the physical page; the three uses never fall in the same cycle.
  always_comb begin
    if (level != LEAF_LEVEL) begin
      add_op = ram_rdata[0] ? ADD_UNBASE : ADD_ALLOC;
    end else begin
      add_op = ADD_STEP;
    end
    case (add_op)
      ADD_UNBASE: begin
        add_a   = ram_rdata[10 +: PPN_W];
        add_b   = ~pool_base;
        add_cin = 1'b1;
      end
      ADD_ALLOC: begin
        add_a   = pool_base;
        add_b   = PPN_W'(next_free);
        add_cin = 1'b0;
      end
      default: begin
        add_a   = ppn;
        add_b   = PPN_W'(1);
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum  = add_a + add_b + PPN_W'(add_cin);
  assign leaf_pte = {10'b0, ppn, 5'b0, perm_r} | PTE_W'(1);
  assign done_inc = done + COUNT_W'(1);

  always_comb begin
    state_next      = state;
    next_free_next  = next_free;
    boot_next       = boot;
    clr_page_next   = clr_page;
    clr_cnt_next    = clr_cnt;
    mode_r_next     = mode_r;
    va_next         = va;
    ppn_next        = ppn;
    count_next      = count;
    perm_r_next     = perm_r;
    done_next       = done;
    leaf_next       = leaf;
    st_next         = st;
    level_next      = level;
    page_next       = page;
    slot_next       = slot;
    out_valid_next  = out_valid && out_stall;
    status_next     = status;
    leaf_entry_next = leaf_entry;
    pages_done_next = pages_done;
    ram_we          = 1'b0;
    ram_addr        = slot;
    ram_wdata       = leaf_pte;

    case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = {clr_page, clr_cnt};
        ram_wdata    = '0;
        clr_cnt_next = clr_cnt + ENTRY_IDX_W'(1);
        if (&clr_cnt) begin
          if (boot) begin
            boot_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            level_next = level - 2'd1;
            state_next = S_READ;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          mode_r_next = mode;
          va_next     = {1'b0, virt_addr};
          ppn_next    = phys_page;
          count_next  = page_count;
          perm_r_next = perm;
          done_next   = '0;
          leaf_next   = '0;
          st_next     = STATUS_OK;
          level_next  = TOP_LEVEL;
          page_next   = '0;
          if (mode == MODE_LOOKUP) begin
            if (virt_addr >= VA_LIMIT) begin
              st_next    = STATUS_VA_LIMIT;
              state_next = S_FINISH;
            end else begin
              state_next = S_READ;
            end
          end else if (page_count == '0) begin
            st_next    = STATUS_ZERO_COUNT;
            state_next = S_FINISH;
          end else if (virt_addr[PAGE_OFS_W-1:0] != '0) begin
            st_next    = STATUS_MISALIGNED;
            state_next = S_FINISH;
          end else begin
            state_next = S_PAGE;
          end
        end
      end

      S_PAGE: begin
        level_next = TOP_LEVEL;
        page_next  = '0;
        if (va >= {1'b0, VA_LIMIT}) begin
          st_next    = STATUS_VA_LIMIT;
          state_next = S_FINISH;
        end else begin
          state_next = S_READ;
        end
      end

      S_READ: begin
        ram_addr   = {page, lvl_idx};
        slot_next  = {page, lvl_idx};
        state_next = S_EVAL;
      end

      S_EVAL: begin
        if (level != LEAF_LEVEL) begin
          if (ram_rdata[0]) begin
            // A pointer that does not name an allocated pool page ends the walk.
            if (add_sum >= PPN_W'(next_free)) begin
              st_next    = STATUS_NOT_PRESENT;
              state_next = S_FINISH;
            end else begin
              page_next  = add_sum[PG_W-1:0];
              level_next = level - 2'd1;
              state_next = S_READ;
            end
          end else if (mode_r == MODE_LOOKUP) begin
            st_next    = STATUS_NOT_PRESENT;
            state_next = S_FINISH;
          end else if (next_free >= POOL_FULL) begin
            st_next    = STATUS_POOL_EMPTY;
            state_next = S_FINISH;
          end else begin
            ram_we         = 1'b1;
            ram_wdata      = {10'b0, add_sum, 10'd1};
            page_next      = next_free[PG_W-1:0];
            clr_page_next  = next_free[PG_W-1:0];
            clr_cnt_next   = '0;
            next_free_next = next_free + CNT_W'(1);
            state_next     = S_CLEAR;
          end
        end else if (mode_r == MODE_LOOKUP) begin
          if (ram_rdata[0]) begin
            leaf_next = ram_rdata;
          end else begin
            st_next = STATUS_NOT_PRESENT;
          end
          state_next = S_FINISH;
        end else if (ram_rdata[0]) begin
          st_next    = STATUS_MAPPED;
          state_next = S_FINISH;
        end else begin
          ram_we    = 1'b1;
          leaf_next = leaf_pte;
          done_next = done_inc;
          va_next   = va + (VA_W + 1)'(4096);
          ppn_next  = add_sum;
          if (done_inc == count) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_PAGE;
          end
        end
      end

      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next  = 1'b1;
          status_next     = st;
          leaf_entry_next = leaf;
          pages_done_next = done;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      next_free <= CNT_W'(1);
      boot      <= 1'b1;
      clr_page  <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      pool_base <= POOL_BASE_RESET;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      boot      <= boot_next;
      clr_page  <= clr_page_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        pool_base <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_r_next;
    va         <= va_next;
    ppn        <= ppn_next;
    count      <= count_next;
    perm_r     <= perm_r_next;
    done       <= done_next;
    leaf       <= leaf_next;
    st         <= st_next;
    level      <= level_next;
    page       <= page_next;
    slot       <= slot_next;
    status     <= status_next;
    leaf_entry <= leaf_entry_next;
    pages_done <= pages_done_next;
  end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the Sv39 page table map and walk block.
module testbench;
  import sv39pt_pkg::*;

  localparam int          POOL_PAGES   = 8;
  localparam int          PAGE_SLOTS   = 512;
  localparam logic [38:0] VA_LIMIT     = 39'd274877906944;
  localparam logic [38:0] TOP_REGION   = VA_LIMIT - 39'h20_0000;
  localparam logic [38:0] ALIAS_REGION = (39'd5 << 30) | (39'd511 << 21);
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          SETTLE       = 8;
  localparam int          END_CYCLES   = 32;
  localparam int          HOLD_AFTER   = 200;
  localparam int          HOLD_CYCLES  = 400;

  typedef struct packed {
    logic                 mode;
    logic [VA_W-1:0]      va;
    logic [PPN_W-1:0]     ppn;
    logic [COUNT_W-1:0]   count;
    logic [PERM_W-1:0]    perm;
  } map_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PTE_W-1:0]     leaf;
    logic [COUNT_W-1:0]   done;
  } map_rsp_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic [PPN_W-1:0]    cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                mode        = MODE_LOOKUP;
  logic [VA_W-1:0]     virt_addr   = '0;
  logic [PPN_W-1:0]    phys_page   = '0;
  logic [COUNT_W-1:0]  page_count  = '0;
  logic [PERM_W-1:0]   perm        = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PTE_W-1:0]    leaf_entry;
  logic [COUNT_W-1:0]  pages_done;

  // Mirror of the table pool, the allocator and the base register.
  logic [PTE_W-1:0]    pt_mem [0:POOL_PAGES*PAGE_SLOTS-1];
  int unsigned         pages_used;
  logic [PPN_W-1:0]    pool_base;

  map_req_t            pending_reqs [$];
  map_rsp_t            expected_rsps [$];

  logic                in_taken    = 1'b0;
  logic                out_taken   = 1'b0;
  int unsigned         idle_left   = 0;
  int unsigned         stall_left  = 0;
  int unsigned         hold_left   = 0;
  bit                  hold_done   = 1'b0;
  bit                  send_calm   = 1'b0;
  bit                  recv_calm   = 1'b0;
  int                  rsp_count   = 0;
  int                  mismatches  = 0;
  int                  cycle_count = 0;

  sv39_page_table_map_walk_top #(
    .POOL_PAGES (POOL_PAGES),
    .VA_LIMIT   (VA_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .virt_addr   (virt_addr),
    .phys_page   (phys_page),
    .page_count  (page_count),
    .perm        (perm),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .leaf_entry  (leaf_entry),
    .pages_done  (pages_done)
  );

  always #6 clk = ~clk;

  function automatic logic [8:0] vpn_slice(input logic [VA_W-1:0] va, input int lvl);
    return va[PAGE_OFS_W + ENTRY_IDX_W*lvl +: ENTRY_IDX_W];
  endfunction

  // Walks from the root and returns the store index of the leaf slot, building
  // missing levels when grow is set.
  function automatic logic [STATUS_W-1:0] locate_leaf(input logic [VA_W-1:0] va,
                                                      input bit grow,
                                                      output int unsigned leaf_at);
    int unsigned      pg;
    int unsigned      slot;
    int               lvl;
    int               j;
    logic [PTE_W-1:0] ent;
    logic [PPN_W-1:0] ofs;
    pg = 0;
    leaf_at = 0;
    for (lvl = 2; lvl > 0; lvl--) begin
      slot = pg * PAGE_SLOTS + vpn_slice(va, lvl);
      ent = pt_mem[slot];
      if (ent[0]) begin
        // Any valid upper entry is treated as a pointer, permission bits or not.
        ofs = ent[53:10] - pool_base;
        if (ofs >= pages_used || ofs >= POOL_PAGES) return STATUS_NOT_PRESENT;
        pg = 32'(ofs[5:0]);
      end else if (!grow) begin
        return STATUS_NOT_PRESENT;
      end else if (pages_used >= POOL_PAGES) begin
        return STATUS_POOL_EMPTY;
      end else begin
        pg = pages_used;
        pages_used++;
        for (j = 0; j < PAGE_SLOTS; j++) pt_mem[pg * PAGE_SLOTS + j] = '0;
        pt_mem[slot] = {10'd0, pool_base + PPN_W'(pg), 9'd0, 1'b1};
      end
    end
    leaf_at = pg * PAGE_SLOTS + vpn_slice(va, 0);
    return STATUS_OK;
  endfunction

  function automatic map_rsp_t walk_and_map(input map_req_t rq);
    map_rsp_t         rsp;
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] ppn;
    logic [PTE_W-1:0] ent;
    logic [2:0]       st;
    int unsigned      at;
    bit               stop;
    rsp = '0;
    stop = 1'b0;
    if (rq.mode == MODE_LOOKUP) begin
      if (rq.va >= VA_LIMIT) begin
        rsp.status = STATUS_VA_LIMIT;
      end else begin
        st = locate_leaf(rq.va, 1'b0, at);
        if (st != STATUS_OK) rsp.status = st;
        else if (!pt_mem[at][0]) rsp.status = STATUS_NOT_PRESENT;
        else rsp.leaf = pt_mem[at];
      end
    end else if (rq.count == '0) begin
      rsp.status = STATUS_ZERO_COUNT;
    end else if (rq.va[PAGE_OFS_W-1:0] != '0) begin
      rsp.status = STATUS_MISALIGNED;
    end else begin
      va = rq.va;
      ppn = rq.ppn;
      while (!stop && rsp.done < rq.count) begin
        if (va >= VA_LIMIT) begin
          rsp.status = STATUS_VA_LIMIT;
          stop = 1'b1;
        end else begin
          st = locate_leaf(va, 1'b1, at);
          if (st != STATUS_OK) begin
            rsp.status = st;
            stop = 1'b1;
          end else if (pt_mem[at][0]) begin
            rsp.status = STATUS_MAPPED;
            stop = 1'b1;
          end else begin
            ent = {10'd0, ppn, 5'd0, rq.perm} | 64'd1;
            pt_mem[at] = ent;
            rsp.leaf = ent;
            rsp.done++;
            va += 39'h1000;
            ppn += 44'd1;
          end
        end
      end
    end
    return rsp;
  endfunction

  function automatic void add_walk_job(input logic m, input logic [VA_W-1:0] va,
                                       input logic [PPN_W-1:0] ppn,
                                       input logic [COUNT_W-1:0] cnt,
                                       input logic [PERM_W-1:0] pm);
    pending_reqs.push_back('{m, va, ppn, cnt, pm});
  endfunction

  // Most addresses land in the few 2 MiB regions that have leaf tables.
  function automatic map_req_t random_request();
    map_req_t    rq;
    int unsigned pick;
    logic [63:0] wide;
    logic [63:0] pwide;
    wide = {$urandom(), $urandom()};
    pwide = {$urandom(), $urandom()};
    rq.mode = ($urandom_range(0, 1) != 0) ? MODE_MAP : MODE_LOOKUP;
    pick = $urandom_range(0, 99);
    if (pick < 45) rq.va = 39'($urandom_range(0, 511)) << 12;
    else if (pick < 75) rq.va = TOP_REGION + (39'($urandom_range(0, 511)) << 12);
    else if (pick < 85) rq.va = ALIAS_REGION + (39'($urandom_range(0, 511)) << 12);
    else rq.va = wide[38:0] & ~39'hFFF;
    rq.ppn = pwide[43:0];
    rq.perm = PERM_W'($urandom_range(0, 30));
    pick = $urandom_range(0, 99);
    if (pick < 3) rq.count = '0;
    else if (pick < 73) rq.count = COUNT_W'($urandom_range(1, 8));
    else if (pick < 88) rq.count = COUNT_W'($urandom_range(9, 64));
    else if (pick < 96) rq.count = COUNT_W'($urandom_range(65, 700));
    else rq.count = COUNT_W'($urandom_range(0, 65535));
    if (rq.mode == MODE_LOOKUP || $urandom_range(0, 19) == 0)
      rq.va[PAGE_OFS_W-1:0] = PAGE_OFS_W'($urandom_range(0, 4095));
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("mismatch on %s at result %0d: got %0h, want %0h", what, rsp_count, got, want);
    mismatches++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_pool_base(input logic [PPN_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pool_base = value;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sv39_page_table_map_walk_top");
      $finish;
    end
  end

  // Checks finished transactions first, then predicts any newly accepted one.
  always @(posedge clk) begin : check_proc
    map_rsp_t want;
    map_req_t seen;
    in_taken <= !rst && in_valid && !in_stall;
    out_taken <= !rst && out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result status", 64'(status), 64'd0);
      end else begin
        want = expected_rsps.pop_front();
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        if (leaf_entry !== want.leaf)
          report_mismatch("leaf_entry", leaf_entry, want.leaf);
        if (pages_done !== want.done)
          report_mismatch("pages_done", 64'(pages_done), 64'(want.done));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      seen = '{mode, virt_addr, phys_page, page_count, perm};
      expected_rsps.push_back(walk_and_map(seen));
    end
  end

  always @(negedge clk) begin : drive_proc
    map_req_t rq;
    if (rst) begin
      in_valid <= 1'b0;
      idle_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (idle_left != 0) begin
        in_valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_reqs.size() != 0) begin
        rq = pending_reqs.pop_front();
        mode <= rq.mode;
        virt_addr <= rq.va;
        phys_page <= rq.ppn;
        page_count <= rq.count;
        perm <= rq.perm;
        in_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        idle_left <= send_calm ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The stall drawn after each result applies to the next one.
  always @(negedge clk) begin : accept_proc
    int unsigned left;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      left = stall_left;
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        left = recv_calm ? 0 : $urandom_range(0, 13);
      end
      if (left != 0 && out_valid) stall_left <= left - 1;
      else stall_left <= left;
      out_stall <= (hold_left != 0) || (left != 0);
    end
  end

  // One long hold-off on the result side while the sender keeps offering.
  always @(negedge clk) begin : hold_proc
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin : stimulus_proc
    int          n;
    logic [63:0] wide;
    for (n = 0; n < POOL_PAGES * PAGE_SLOTS; n++) pt_mem[n] = '0;
    pages_used = 1;
    pool_base = POOL_BASE_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Error codes, offsets ignored on lookup, a run cut short by the VA limit,
    // physical page wrap and a run stopped by an existing mapping.
    add_walk_job(MODE_LOOKUP, 39'h0, 44'h0, 16'd0, 5'd0);
    add_walk_job(MODE_MAP, 39'h0, 44'h0, 16'd0, 5'd2);
    add_walk_job(MODE_MAP, 39'h123, 44'h0, 16'd1, 5'd2);
    add_walk_job(MODE_MAP, 39'h7, 44'h0, 16'd0, 5'd2);
    add_walk_job(MODE_MAP, 39'h0, 44'h0, 16'd1, 5'd2);
    add_walk_job(MODE_LOOKUP, 39'hFFF, 44'h0, 16'd0, 5'd0);
    add_walk_job(MODE_MAP, 39'h0, 44'h5, 16'd1, 5'd4);
    add_walk_job(MODE_MAP, VA_LIMIT - 39'h2000, 44'hABC, 16'd5, 5'd30);
    add_walk_job(MODE_LOOKUP, VA_LIMIT, 44'h0, 16'd0, 5'd0);
    add_walk_job(MODE_LOOKUP, 39'h7F_FFFF_FFFF, 44'hFFF_FFFF_FFFF, 16'hFFFF, 5'd30);
    add_walk_job(MODE_MAP, 39'h7F_FFFF_F000, 44'h1, 16'd1, 5'd2);
    add_walk_job(MODE_MAP, 39'h1000, 44'hFFF_FFFF_FFFE, 16'd4, 5'd16);
    add_walk_job(MODE_MAP, 39'h8000, 44'h555_5555_5555, 16'd1, 5'd29);
    add_walk_job(MODE_LOOKUP, 39'h6000, 44'h0, 16'd0, 5'd0);
    add_walk_job(MODE_MAP, 39'h6000, 44'hAAA_AAAA_AAAA, 16'hFFFF, 5'd10);

    // Highest base: new table pointers wrap, old ones fall outside the pool.
    write_pool_base(44'hFFF_FFFF_FFFF);
    add_walk_job(MODE_MAP, 39'h1_C000_0000, 44'h123_4567_89AB, 16'd3, 5'd6);
    add_walk_job(MODE_LOOKUP, 39'h1_C000_2000, 44'h0, 16'd0, 5'd0);
    add_walk_job(MODE_LOOKUP, 39'h0, 44'h0, 16'd0, 5'd0);

    // Zero base: the pool runs dry with a new upper table left linked.
    write_pool_base(44'h0);
    add_walk_job(MODE_LOOKUP, 39'h1_C000_0000, 44'h0, 16'd0, 5'd0);
    add_walk_job(MODE_MAP, 39'h2_4000_0000, 44'h77, 16'd2, 5'd2);
    add_walk_job(MODE_LOOKUP, 39'h2_4000_0000, 44'h0, 16'd0, 5'd0);

    // Base shifted by one page makes the root its own child, so a leaf with
    // permission bits ends up in the root and is later walked as a pointer.
    write_pool_base(POOL_BASE_RESET + 44'd1);
    add_walk_job(MODE_MAP, 39'h5000, POOL_BASE_RESET + 44'd3, 16'd1, 5'd14);
    add_walk_job(MODE_LOOKUP, 39'h1_4000_0000, 44'h0, 16'd0, 5'd0);

    write_pool_base(POOL_BASE_RESET);
    for (n = 0; n < 500; n++) pending_reqs.push_back(random_request());

    wide = {$urandom(), $urandom()};
    write_pool_base(wide[43:0]);
    for (n = 0; n < 30; n++) pending_reqs.push_back(random_request());

    write_pool_base(POOL_BASE_RESET);
    for (n = 0; n < 270; n++) pending_reqs.push_back(random_request());

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS sv39_page_table_map_walk_top");
    end else begin
      $display("FAIL sv39_page_table_map_walk_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sv39pt_pkg.sv
rtl/core/sv39pt_table_ram.sv
rtl/core/sv39_page_table_map_walk_top.sv
test/testbench.sv
